[rtl/core/ose_pkg.sv]
// shared types, codes and sizes for the operand stack engine
`default_nettype none

package ose_pkg;

  // default build sizes
  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned WIDTH_DEF = 32;

  // fixed field widths of the item ports
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned OFF_W    = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CNT_W    = 7;

  // operation codes carried by the kind field
  typedef enum logic [KIND_W-1:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_DUP   = 3'd2,
    OP_SWAP  = 3'd3,
    OP_ROT   = 3'd4,
    OP_PEEK  = 3'd5,
    OP_CLEAR = 3'd6
  } op_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_RD_C,
    S_WAIT,
    S_WR_N,
    S_WR_A,
    S_WR_B,
    S_WR_C,
    S_DONE
  } state_e;

  // stack slot addressed by a memory access, counted down from the fill count
  typedef enum logic [2:0] {
    SLOT_PEEK,
    SLOT_FREE,
    SLOT_1,
    SLOT_2,
    SLOT_3
  } slot_e;

  // holding register selection
  typedef enum logic [1:0] {
    REG_A,
    REG_B,
    REG_C
  } reg_sel_e;

  // write data source
  typedef enum logic [1:0] {
    WSRC_VAL,
    WSRC_A,
    WSRC_B,
    WSRC_C
  } wsrc_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic     load;
    logic     rd;
    reg_sel_e rd_tag;
    logic     wr;
    slot_e    slot;
    wsrc_e    wsrc;
    logic     finish;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [KIND_W-1:0] in_kind;
    logic              in_err;
    logic [KIND_W-1:0] cur_kind;
    logic              out_free;
  } stat_t;

endpackage

`default_nettype wire

[rtl/core/ose_ram.sv]
// generic single-port ram with registered read
`default_nettype none

module ose_ram #(
  parameter int unsigned W = 32,
  parameter int unsigned D = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic                 re_i,
  input  wire logic [$clog2(D)-1:0] addr_i,
  input  wire logic [W-1:0]         wdata_i,
  output logic      [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  // one access per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/ose_ctrl.sv]
// sequencer for the stack memory accesses of one operation
`default_nettype none

module ose_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ose_pkg::stat_t stat_i,
  output ose_pkg::cmd_t      cmd_o
);

  import ose_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (stat_i.in_err) begin
            state_d = S_DONE;
          end else if (stat_i.in_kind == OP_PUSH) begin
            state_d = S_WR_N;
          end else if (stat_i.in_kind inside {OP_POP, OP_PEEK, OP_DUP, OP_SWAP, OP_ROT}) begin
            state_d = S_RD_A;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_RD_A: begin
        if (stat_i.cur_kind inside {OP_SWAP, OP_ROT}) begin
          state_d = S_RD_B;
        end else begin
          state_d = S_WAIT;
        end
      end
      S_RD_B: begin
        if (stat_i.cur_kind == OP_ROT) begin
          state_d = S_RD_C;
        end else begin
          state_d = S_WAIT;
        end
      end
      S_RD_C: state_d = S_WAIT;
      S_WAIT: begin
        if (stat_i.cur_kind == OP_DUP) begin
          state_d = S_WR_N;
        end else if (stat_i.cur_kind inside {OP_SWAP, OP_ROT}) begin
          state_d = S_WR_A;
        end else begin
          state_d = S_DONE;
        end
      end
      S_WR_N: state_d = S_DONE;
      S_WR_A: state_d = S_WR_B;
      S_WR_B: begin
        if (stat_i.cur_kind == OP_ROT) begin
          state_d = S_WR_C;
        end else begin
          state_d = S_DONE;
        end
      end
      S_WR_C: state_d = S_DONE;
      S_DONE: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_tag = REG_A;
    cmd_o.slot   = SLOT_PEEK;
    cmd_o.wsrc   = WSRC_VAL;
    in_ready_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_RD_A: begin
        // peek reads at its offset, every other operation reads the top
        cmd_o.rd     = 1'b1;
        cmd_o.rd_tag = REG_A;
        cmd_o.slot   = (stat_i.cur_kind == OP_PEEK) ? SLOT_PEEK : SLOT_1;
      end
      S_RD_B: begin
        cmd_o.rd     = 1'b1;
        cmd_o.rd_tag = REG_B;
        cmd_o.slot   = SLOT_2;
      end
      S_RD_C: begin
        cmd_o.rd     = 1'b1;
        cmd_o.rd_tag = REG_C;
        cmd_o.slot   = SLOT_3;
      end
      S_WR_N: begin
        cmd_o.wr   = 1'b1;
        cmd_o.slot = SLOT_FREE;
        cmd_o.wsrc = (stat_i.cur_kind == OP_PUSH) ? WSRC_VAL : WSRC_A;
      end
      S_WR_A: begin
        cmd_o.wr   = 1'b1;
        cmd_o.slot = SLOT_1;
        cmd_o.wsrc = (stat_i.cur_kind == OP_ROT) ? WSRC_C : WSRC_B;
      end
      S_WR_B: begin
        cmd_o.wr   = 1'b1;
        cmd_o.slot = SLOT_2;
        cmd_o.wsrc = WSRC_A;
      end
      S_WR_C: begin
        cmd_o.wr   = 1'b1;
        cmd_o.slot = SLOT_3;
        cmd_o.wsrc = WSRC_B;
      end
      S_DONE: cmd_o.finish = stat_i.out_free;
      default: ;
    endcase
  end

  // single memory port: never a read and a write together
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(cmd_o.rd && cmd_o.wr))
    else $error("read and write issued in the same cycle");

  // an accepted item always leaves idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_o.load |=> state_q != S_IDLE)
    else $error("accepted transfer did not start a sequence");

  // a write sequence ends with completion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR_N || state_q == S_WR_C) |=> state_q == S_DONE)
    else $error("last write not followed by completion");

endmodule

`default_nettype wire

[rtl/core/ose_dp.sv]
// datapath: fill count, holding registers, stack memory and result register
`default_nettype none

module ose_dp #(
  parameter int unsigned DEPTH = ose_pkg::DEPTH_DEF,
  parameter int unsigned WIDTH = ose_pkg::WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire ose_pkg::cmd_t                  cmd_i,
  output ose_pkg::stat_t                      stat_o,
  input  wire logic [ose_pkg::KIND_W-1:0]     kind_i,
  input  wire logic [ose_pkg::VALUE_W-1:0]    push_value_i,
  input  wire logic [ose_pkg::OFF_W-1:0]      depth_offset_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [ose_pkg::VALUE_W-1:0]    read_value_o,
  output logic      [ose_pkg::STATUS_W-1:0]   status_o,
  output logic      [ose_pkg::CNT_W-1:0]      item_count_o
);

  import ose_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = (CW > OFF_W) ? CW : OFF_W;

  logic [CW-1:0]       count_q, count_d;
  logic [KIND_W-1:0]   kind_q;
  logic [WIDTH-1:0]    val_q;
  logic [OFF_W-1:0]    off_q;
  status_e             status_q, in_status;
  logic [WIDTH-1:0]    a_q, b_q, c_q;
  logic                pend_q;
  reg_sel_e            pend_tag_q;
  logic                out_valid_q;
  logic [VALUE_W-1:0]  read_value_q, read_value_d;
  logic [STATUS_W-1:0] status_out_q;
  logic [CNT_W-1:0]    item_count_q;
  logic                full;
  logic [AW-1:0]       n_a, addr;
  logic [WIDTH-1:0]    wdata, rdata;
  logic [63:0]         a_ext;

  // status of the offered item against the current fill
  assign full = (count_q == CW'(DEPTH));
  always_comb begin
    in_status = ST_OK;
    case (kind_i)
      OP_PUSH:  if (full) in_status = ST_OVER;
      OP_POP:   if (count_q == '0) in_status = ST_UNDER;
      OP_DUP: begin
        if (count_q == '0) begin
          in_status = ST_UNDER;
        end else if (full) begin
          in_status = ST_OVER;
        end
      end
      OP_SWAP:  if (count_q < CW'(2)) in_status = ST_UNDER;
      OP_ROT:   if (count_q < CW'(3)) in_status = ST_UNDER;
      OP_PEEK:  if (SW'(depth_offset_i) >= SW'(count_q)) in_status = ST_UNDER;
      default:  in_status = ST_OK;
    endcase
  end

  assign stat_o.in_kind  = kind_i;
  assign stat_o.in_err   = (in_status != ST_OK);
  assign stat_o.cur_kind = kind_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // operand capture on transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= kind_i;
      val_q    <= WIDTH'(push_value_i);
      off_q    <= depth_offset_i;
      status_q <= in_status;
    end
  end

  // memory address and write data
  assign n_a = AW'(count_q);
  always_comb begin
    case (cmd_i.slot)
      SLOT_PEEK: addr = n_a - AW'(1) - AW'(off_q);
      SLOT_FREE: addr = n_a;
      SLOT_1:    addr = n_a - AW'(1);
      SLOT_2:    addr = n_a - AW'(2);
      SLOT_3:    addr = n_a - AW'(3);
      default:   addr = n_a;
    endcase
  end

  always_comb begin
    case (cmd_i.wsrc)
      WSRC_VAL: wdata = val_q;
      WSRC_A:   wdata = a_q;
      WSRC_B:   wdata = b_q;
      WSRC_C:   wdata = c_q;
      default:  wdata = val_q;
    endcase
  end

  ose_ram #(
    .W (WIDTH),
    .D (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr),
    .re_i    (cmd_i.rd),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  // pending read tracking, read data arrives in the cycle after the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= 1'b0;
      pend_tag_q <= REG_A;
    end else begin
      pend_q     <= cmd_i.rd;
      pend_tag_q <= cmd_i.rd_tag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      case (pend_tag_q)
        REG_A:   a_q <= rdata;
        REG_B:   b_q <= rdata;
        REG_C:   c_q <= rdata;
        default: a_q <= rdata;
      endcase
    end
  end

  // fill count after the operation
  always_comb begin
    count_d = count_q;
    if (status_q == ST_OK) begin
      case (kind_q)
        OP_PUSH:  count_d = count_q + CW'(1);
        OP_DUP:   count_d = count_q + CW'(1);
        OP_POP:   count_d = count_q - CW'(1);
        OP_CLEAR: count_d = '0;
        default:  count_d = count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.finish) begin
      count_q <= count_d;
    end
  end

  // returned value: only pop and peek give one
  assign a_ext = 64'(a_q);
  always_comb begin
    read_value_d = '0;
    if (status_q == ST_OK && (kind_q == OP_POP || kind_q == OP_PEEK)) begin
      read_value_d = a_ext[VALUE_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      read_value_q <= read_value_d;
      status_out_q <= status_q;
      item_count_q <= CNT_W'(count_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign status_o     = status_out_q;
  assign item_count_o = item_count_q;

  // fill never exceeds the built depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(DEPTH))
    else $error("fill count beyond depth");

  // the free slot is written only when there is room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr && cmd_i.slot == SLOT_FREE) |-> !full)
    else $error("write past the top of a full stack");

  // a failed operation leaves the fill count alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && status_q != ST_OK) |=> count_q == $past(count_q))
    else $error("fill count changed on an error");

  // completion never overwrites an untaken result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before transfer");

endmodule

`default_nettype wire

[rtl/core/operand_stack_engine_core.sv]
// top level of the operand stack engine
`default_nettype none

// Bounded LIFO operand stack of DEPTH entries, WIDTH bits each, held in a
// single-port memory with registered read. One operation is taken at a time;
// its result waits in an output register so the next operation may be taken
// while that result is still unclaimed. On the one memory port, push writes
// the free slot; pop and peek read one entry; dup reads the top and writes it
// to the free slot; swap and rot read and write two and three entries; clear
// and any failing operation make no access. Errors (underflow, overflow)
// leave the stack untouched. item_count shows the low 7 bits of the fill count.
module operand_stack_engine_core #(
  parameter int unsigned DEPTH = ose_pkg::DEPTH_DEF,
  parameter int unsigned WIDTH = ose_pkg::WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [ose_pkg::KIND_W-1:0]   kind_i,
  input  wire logic [ose_pkg::VALUE_W-1:0]  push_value_i,
  input  wire logic [ose_pkg::OFF_W-1:0]    depth_offset_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [ose_pkg::VALUE_W-1:0]  read_value_o,
  output logic      [ose_pkg::STATUS_W-1:0] status_o,
  output logic      [ose_pkg::CNT_W-1:0]    item_count_o
);

  import ose_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  ose_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // storage and result path
  ose_dp #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .kind_i         (kind_i),
    .push_value_i   (push_value_i),
    .depth_offset_i (depth_offset_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .read_value_o   (read_value_o),
    .status_o       (status_o),
    .item_count_o   (item_count_o)
  );

endmodule

`default_nettype wire

[sim/operand_stack_engine_core_checker.sv]
// result checker for the operand stack engine: stack prediction and field compare
module operand_stack_engine_core_checker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  input  wire logic                         in_ready_i,
  input  wire logic [ose_pkg::KIND_W-1:0]   kind_i,
  input  wire logic [ose_pkg::VALUE_W-1:0]  push_value_i,
  input  wire logic [ose_pkg::OFF_W-1:0]    depth_offset_i,
  input  wire logic                         out_valid_i,
  input  wire logic                         out_ready_i,
  input  wire logic [ose_pkg::VALUE_W-1:0]  read_value_i,
  input  wire logic [ose_pkg::STATUS_W-1:0] status_i,
  input  wire logic [ose_pkg::CNT_W-1:0]    item_count_i,
  output int unsigned                       fail_count_o,
  output int unsigned                       results_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import ose_pkg::*;

  // one stack result as the block reports it
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    status_e            status;
    logic [CNT_W-1:0]   count;
  } stack_result_t;

  // shadow stack, entry 0 is the bottom; stored width equals the value field
  logic [VALUE_W-1:0] shadow_mem [DEPTH_DEF];
  int unsigned        shadow_fill = 0;

  stack_result_t results_due [$];
  int unsigned   mismatches = 0;
  int unsigned   due_count  = 0;

  assign fail_count_o  = mismatches;
  assign results_due_o = due_count;

  // apply one operation to the shadow stack and return its result
  function automatic stack_result_t apply_stack_op(input logic [KIND_W-1:0]  op,
                                                   input logic [VALUE_W-1:0] val,
                                                   input logic [OFF_W-1:0]   off);
    stack_result_t      res;
    logic [VALUE_W-1:0] top_a, top_b, top_c;
    int unsigned        n;
    n          = shadow_fill;
    res.value  = '0;
    res.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (n >= DEPTH_DEF) res.status = ST_OVER;
        else begin
          shadow_mem[n] = val;
          n++;
        end
      end
      OP_POP: begin
        if (n == 0) res.status = ST_UNDER;
        else begin
          res.value = shadow_mem[n-1];
          n--;
        end
      end
      OP_DUP: begin
        if (n == 0) res.status = ST_UNDER;
        else if (n >= DEPTH_DEF) res.status = ST_OVER;
        else begin
          shadow_mem[n] = shadow_mem[n-1];
          n++;
        end
      end
      OP_SWAP: begin
        if (n < 2) res.status = ST_UNDER;
        else begin
          top_a           = shadow_mem[n-1];
          shadow_mem[n-1] = shadow_mem[n-2];
          shadow_mem[n-2] = top_a;
        end
      end
      OP_ROT: begin
        // A B C with A on top becomes C A B
        if (n < 3) res.status = ST_UNDER;
        else begin
          top_a           = shadow_mem[n-1];
          top_b           = shadow_mem[n-2];
          top_c           = shadow_mem[n-3];
          shadow_mem[n-1] = top_c;
          shadow_mem[n-2] = top_a;
          shadow_mem[n-3] = top_b;
        end
      end
      OP_PEEK: begin
        // an offset at or past the fill count reads nothing
        if (off >= n) res.status = ST_UNDER;
        else res.value = shadow_mem[n-1-off];
      end
      OP_CLEAR: n = 0;
      default: ;  // unused code leaves the stack alone
    endcase
    shadow_fill = n;
    res.count   = CNT_W'(n);
    return res;
  endfunction

  // compare each result transfer, then predict each input transfer
  always @(posedge clk_i or negedge rst_ni) begin
    stack_result_t exp_res;
    if (!rst_ni) begin
      shadow_fill = 0;
      results_due.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (results_due.size() == 0) begin
          $error("result transfer with no operation outstanding: value %h status %0d count %0d",
                 read_value_i, status_i, item_count_i);
          mismatches++;
        end else begin
          exp_res = results_due.pop_front();
          if (read_value_i !== exp_res.value) begin
            $error("read_value: expected %h, got %h", exp_res.value, read_value_i);
            mismatches++;
          end
          if (status_i !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, status_i);
            mismatches++;
          end
          if (item_count_i !== exp_res.count) begin
            $error("item_count: expected %0d, got %0d", exp_res.count, item_count_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        results_due.push_back(apply_stack_op(kind_i, push_value_i, depth_offset_i));
    end
    due_count = results_due.size();
  end

endmodule

[sim/operand_stack_engine_core_tb.sv]
// testbench top for the operand stack engine: stimulus, flow control and verdict
module operand_stack_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ose_pkg::*;

  // the one kind code that names no operation
  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
  localparam int unsigned RANDOM_OPS = 800;

  // operation mixes for the random segments
  typedef enum {MIX_FILL, MIX_DRAIN, MIX_SHUFFLE, MIX_ANY} mix_e;
  // result-side flow patterns
  typedef enum {RDY_ALWAYS, RDY_CHOPPY, RDY_LONG_STALL} ready_mix_e;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [KIND_W-1:0]   kind = '0;
  logic [VALUE_W-1:0]  push_value = '0;
  logic [OFF_W-1:0]    depth_offset = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [VALUE_W-1:0]  read_value;
  logic [STATUS_W-1:0] status;
  logic [CNT_W-1:0]    item_count;

  int unsigned fail_count;
  int unsigned results_due;
  int unsigned burst_left = 1;

  operand_stack_engine_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .kind_i         (kind),
    .push_value_i   (push_value),
    .depth_offset_i (depth_offset),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .read_value_o   (read_value),
    .status_o       (status),
    .item_count_o   (item_count)
  );

  operand_stack_engine_core_checker result_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .kind_i         (kind),
    .push_value_i   (push_value),
    .depth_offset_i (depth_offset),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .read_value_i   (read_value),
    .status_i       (status),
    .item_count_i   (item_count),
    .fail_count_o   (fail_count),
    .results_due_o  (results_due)
  );

  // 12 ns clock
  initial begin
    forever #6 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #3_000_000;
    $display("** operand_stack_engine_core: FAILED **");
    $finish;
  end

  // result side: switch between flow patterns every so often
  ready_mix_e  ready_mix = RDY_ALWAYS;
  int unsigned mix_left  = 0;
  int unsigned hold_left = 0;

  always @(posedge clk) begin
    if (mix_left == 0) begin
      ready_mix = ready_mix_e'($urandom_range(2));
      mix_left  = $urandom_range(40, 200);
    end
    mix_left--;
    if (hold_left == 0) begin
      case (ready_mix)
        RDY_ALWAYS: begin
          out_ready <= 1'b1;
          hold_left = 1;
        end
        RDY_CHOPPY: begin
          out_ready <= 1'($urandom_range(1));
          hold_left = $urandom_range(1, 3);
        end
        default: begin
          if (out_ready) begin
            out_ready <= 1'b0;
            hold_left = $urandom_range(1, 20);
          end else begin
            out_ready <= 1'b1;
            hold_left = $urandom_range(4, 30);
          end
        end
      endcase
    end
    hold_left--;
  end

  // offer one operation and hold it until the transfer, then maybe pause
  task automatic send_op(input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] v,
                         input logic [OFF_W-1:0] o);
    int unsigned gap;
    in_valid     <= 1'b1;
    kind         <= k;
    push_value   <= v;
    depth_offset <= o;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
      gap        = $urandom_range(0, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // random operation drawn from a mix
  task automatic pick_op(input mix_e mix, output logic [KIND_W-1:0] k,
                         output logic [VALUE_W-1:0] v, output logic [OFF_W-1:0] o);
    int unsigned roll;
    int unsigned vroll;
    roll  = $urandom_range(99);
    vroll = $urandom_range(99);
    v = (vroll < 8) ? '1 : (vroll < 16) ? '0 : VALUE_W'($urandom());
    o = ($urandom_range(1) != 0) ? OFF_W'($urandom_range(7)) : OFF_W'($urandom_range(63));
    case (mix)
      MIX_FILL:
        k = (roll < 85) ? OP_PUSH : (roll < 90) ? OP_DUP : (roll < 94) ? OP_PEEK :
            (roll < 97) ? OP_SWAP : OP_ROT;
      MIX_DRAIN:
        k = (roll < 55) ? OP_POP : (roll < 70) ? OP_PEEK : (roll < 80) ? OP_SWAP :
            (roll < 90) ? OP_ROT : OP_PUSH;
      MIX_SHUFFLE:
        k = (roll < 30) ? OP_PUSH : (roll < 50) ? OP_POP : (roll < 65) ? OP_SWAP :
            (roll < 80) ? OP_ROT : (roll < 95) ? OP_PEEK : OP_DUP;
      default:
        k = KIND_W'($urandom_range(7));
    endcase
  endtask

  // reset, directed corner cases, random segments, drain and verdict
  initial begin
    logic [KIND_W-1:0]  k;
    logic [VALUE_W-1:0] v;
    logic [OFF_W-1:0]   o;
    mix_e               seg_mix;
    int unsigned        seg_left;
    int unsigned        counted;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every operation but push and clear on an empty stack, and the unused code
    send_op(OP_POP, '0, '0);
    send_op(OP_DUP, '0, '0);
    send_op(OP_SWAP, '0, '0);
    send_op(OP_ROT, '0, '0);
    send_op(OP_PEEK, '0, '0);
    send_op(KIND_UNUSED, '1, '1);
    // too few items for swap and rot, peek at or past the count
    send_op(OP_PUSH, 32'hFFFF_FFFF, '0);
    send_op(OP_SWAP, '0, '0);
    send_op(OP_PUSH, 32'h0000_0000, '1);
    send_op(OP_ROT, '0, '0);
    send_op(OP_PEEK, '0, 6'd2);
    send_op(OP_PEEK, '0, 6'd63);
    // well-formed use with three or more items, then clear, pop when empty, push
    send_op(OP_PUSH, 32'hA5A5_5A5A, '0);
    send_op(OP_ROT, '0, '0);
    send_op(OP_SWAP, '0, '0);
    send_op(OP_DUP, '0, '0);
    send_op(OP_PEEK, '0, 6'd3);
    send_op(OP_PEEK, '0, 6'd0);
    send_op(OP_POP, '0, '0);
    send_op(KIND_UNUSED, 32'h5A5A_A5A5, 6'h2A);
    send_op(OP_CLEAR, '1, '1);
    send_op(OP_POP, '0, '0);
    send_op(OP_PUSH, 32'h8000_0001, '0);

    // random segments, the first one filling the stack to overflow
    seg_mix  = MIX_FILL;
    seg_left = 100;
    counted  = 0;
    while (counted < RANDOM_OPS) begin
      if (seg_left == 0) begin
        seg_mix  = mix_e'($urandom_range(3));
        seg_left = $urandom_range(20, 100);
      end
      pick_op(seg_mix, k, v, o);
      send_op(k, v, o);
      seg_left--;
      if (k != KIND_UNUSED) counted++;
    end
    in_valid <= 1'b0;

    // let every outstanding result come back, then a few more cycles
    while (results_due != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (fail_count == 0 && results_due == 0) begin
      $display("** operand_stack_engine_core: PASSED **");
    end else begin
      $display("** operand_stack_engine_core: FAILED **");
    end
    $finish;
  end

endmodule
